@@ hdl/bgc_pkg.sv @@
// shared types, event codes and register defaults for the button gesture classifier
package bgc_pkg;

    // gesture event codes
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_PRESS      = 3'd1;
    localparam logic [2:0] EV_RELEASE    = 3'd2;
    localparam logic [2:0] EV_LONG_EXIT  = 3'd3;
    localparam logic [2:0] EV_PAUSE      = 3'd4;
    localparam logic [2:0] EV_MENU_ENTER = 3'd5;
    localparam logic [2:0] EV_MENU_EXIT  = 3'd6;
    localparam logic [2:0] EV_SINGLE     = 3'd7;

    // configuration register indexes
    localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd1;
    localparam logic [1:0] REG_DOUBLE_CLICK = 2'd2;

    // configuration reset values
    localparam logic [15:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
    localparam logic [15:0] DOUBLE_CLICK_RST = 16'd300;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] hold_ms;
        logic [15:0] click_window_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0] gesture_event;
        logic       menu_open;
        logic       paused;
        logic       adjust_off;
        logic       edit_mode;
        logic       selection_reset;
        logic       edit_touched;
        logic       display_refresh;
    } t_result;

endpackage

@@ hdl/bgc_cfg_regs.sv @@
// configuration registers for the timing thresholds
module bgc_cfg_regs
    import bgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // register write, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms     <= DEBOUNCE_RST;
            r_cfg.hold_ms         <= LONG_PRESS_RST;
            r_cfg.click_window_ms <= DOUBLE_CLICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:     r_cfg.debounce_ms     <= i_cfg_data;
                REG_LONG_PRESS:   r_cfg.hold_ms         <= i_cfg_data;
                REG_DOUBLE_CLICK: r_cfg.click_window_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/bgc_step.sv @@
// gesture state registers and the per-poll classification logic
module bgc_step
    import bgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [31:0] i_now_ms,
    input  logic        i_button_level,
    input  t_cfg        i_cfg,
    output t_result     o_result
);

    logic        r_prev_level, n_prev_level;
    logic        r_long_fired, n_long_fired;
    logic        r_single_pending, n_single_pending;
    logic [1:0]  r_click_count, n_click_count;
    logic [31:0] r_press_time, n_press_time;
    logic [31:0] r_last_edge, n_last_edge;
    logic [31:0] r_last_release, n_last_release;
    logic        r_menu, n_menu;
    logic        r_pause, n_pause;
    logic        r_adjust, n_adjust;
    logic        r_edit, n_edit;

    logic [31:0] since_edge;
    logic [31:0] held;
    logic [31:0] since_release;
    logic        debounced;
    logic        long_reached;
    logic        in_window;
    logic [1:0]  click_inc;
    logic [2:0]  ev;
    logic        sel;
    logic        touch;
    logic        refresh;

    // elapsed times, all modulo 2^32
    assign since_edge    = i_now_ms - r_last_edge;
    assign held          = i_now_ms - r_press_time;
    assign since_release = i_now_ms - r_last_release;
    assign debounced     = since_edge < {16'd0, i_cfg.debounce_ms};
    assign long_reached  = held >= {16'd0, i_cfg.hold_ms};
    assign in_window     = since_release < {16'd0, i_cfg.click_window_ms};
    assign click_inc     = r_click_count + 2'd1;

    // next state and event for one poll
    always_comb begin
        n_prev_level     = r_prev_level;
        n_long_fired     = r_long_fired;
        n_single_pending = r_single_pending;
        n_click_count    = r_click_count;
        n_press_time     = r_press_time;
        n_last_edge      = r_last_edge;
        n_last_release   = r_last_release;
        n_menu           = r_menu;
        n_pause          = r_pause;
        n_adjust         = r_adjust;
        n_edit           = r_edit;
        ev               = EV_NONE;
        sel              = 1'b0;
        touch            = 1'b0;
        refresh          = 1'b0;
        priority if (debounced) begin
            ev = EV_NONE;
        end else if (i_button_level && !r_prev_level) begin
            // press edge
            n_press_time = i_now_ms;
            n_last_edge  = i_now_ms;
            n_long_fired = 1'b0;
            n_prev_level = 1'b1;
            ev           = EV_PRESS;
        end else if (i_button_level && !r_long_fired && long_reached) begin
            // long press while held, fires once
            if (r_menu) begin
                n_menu = 1'b0;
                n_edit = 1'b0;
                sel    = 1'b1;
                ev     = EV_LONG_EXIT;
            end else begin
                n_pause = ~r_pause;
                ev      = EV_PAUSE;
            end
            n_long_fired = 1'b1;
            refresh      = 1'b1;
        end else if (!i_button_level && r_prev_level) begin
            // release edge
            n_last_edge  = i_now_ms;
            n_prev_level = 1'b0;
            ev           = EV_RELEASE;
            if (r_long_fired) begin
                n_long_fired = 1'b0;
            end else if (!long_reached) begin
                n_last_release = i_now_ms;
                if (!in_window) begin
                    n_click_count    = 2'd1;
                    n_single_pending = 1'b1;
                end else if (click_inc == 2'd2) begin
                    // double click toggles the menu
                    if (r_menu) begin
                        n_menu = 1'b0;
                        n_edit = 1'b0;
                        ev     = EV_MENU_EXIT;
                    end else begin
                        n_menu = 1'b1;
                        ev     = EV_MENU_ENTER;
                    end
                    n_click_count    = 2'd0;
                    n_single_pending = 1'b0;
                    sel              = 1'b1;
                    refresh          = 1'b1;
                end else begin
                    n_click_count = click_inc;
                end
            end
        end else begin
            // quiet poll, may confirm a pending single click
            n_prev_level = i_button_level;
            if (r_click_count == 2'd1 && r_single_pending && !in_window) begin
                if (!r_menu) begin
                    n_adjust = ~r_adjust;
                    n_edit   = 1'b1;
                end else begin
                    n_edit = ~r_edit;
                end
                n_click_count    = 2'd0;
                n_single_pending = 1'b0;
                ev               = EV_SINGLE;
                touch            = 1'b1;
                refresh          = 1'b1;
            end
        end
    end

    // state update on each processed poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level     <= 1'b0;
            r_long_fired     <= 1'b0;
            r_single_pending <= 1'b0;
            r_click_count    <= 2'd0;
            r_press_time     <= 32'd0;
            r_last_edge      <= 32'd0;
            r_last_release   <= 32'd0;
            r_menu           <= 1'b0;
            r_pause          <= 1'b0;
            r_adjust         <= 1'b0;
            r_edit           <= 1'b0;
        end else if (i_step) begin
            r_prev_level     <= n_prev_level;
            r_long_fired     <= n_long_fired;
            r_single_pending <= n_single_pending;
            r_click_count    <= n_click_count;
            r_press_time     <= n_press_time;
            r_last_edge      <= n_last_edge;
            r_last_release   <= n_last_release;
            r_menu           <= n_menu;
            r_pause          <= n_pause;
            r_adjust         <= n_adjust;
            r_edit           <= n_edit;
        end
    end

    // result shows status after the step
    always_comb begin
        o_result.gesture_event   = ev;
        o_result.menu_open       = n_menu;
        o_result.paused          = n_pause;
        o_result.adjust_off      = n_adjust;
        o_result.edit_mode       = n_edit;
        o_result.selection_reset = sel;
        o_result.edit_touched    = touch;
        o_result.display_refresh = refresh;
    end

    // a press leaves the button held with the long press re-armed
    a_press_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && ev == EV_PRESS |=> r_prev_level && !r_long_fired)
        else $error("press did not arm hold tracking");

    // a double click clears the click bookkeeping
    a_double_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (ev == EV_MENU_ENTER || ev == EV_MENU_EXIT)
        |=> r_click_count == 2'd0 && !r_single_pending)
        else $error("double click left clicks pending");

    // a confirmed single click consumes the pending click
    a_single_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && ev == EV_SINGLE |=> !r_single_pending && r_click_count == 2'd0)
        else $error("single click still pending after confirmation");

    // mode state only moves on a processed poll
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_menu) && $stable(r_pause) && $stable(r_adjust)
                    && $stable(r_edit))
        else $error("mode state changed without a poll");

endmodule

@@ hdl/button_gesture_classifier_core.sv @@
// top level: input register, gesture classification and result register
// data path: a poll is captured in the input register and then loaded into the result
//   register, which raises o_valid; the load waits while the output is stalled
// throughput: one poll per cycle while i_ready keeps the output free
// reset: synchronous active-low i_rst_n clears all gesture state, empties both
//   registers and restores the thresholds to 50, 1000 and 300 ms
module button_gesture_classifier_core
    import bgc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_now_ms,
    input  logic        i_button_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_gesture_event,
    output logic        o_menu_open,
    output logic        o_paused,
    output logic        o_adjust_off,
    output logic        o_edit_mode,
    output logic        o_selection_reset,
    output logic        o_edit_touched,
    output logic        o_display_refresh,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_in_valid;
    logic [31:0] r_now_ms;
    logic        r_level;
    logic        r_out_valid;
    t_result     r_result;
    t_result     step_result;
    t_cfg        cfg;
    logic        step;

    // a held poll is processed when the result register can take it
    assign step    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_now_ms <= i_now_ms;
            r_level  <= i_button_level;
        end
    end

    bgc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bgc_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_now_ms       (r_now_ms),
        .i_button_level (r_level),
        .i_cfg          (cfg),
        .o_result       (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= step_result;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_gesture_event   = r_result.gesture_event;
    assign o_menu_open       = r_result.menu_open;
    assign o_paused          = r_result.paused;
    assign o_adjust_off      = r_result.adjust_off;
    assign o_edit_mode       = r_result.edit_mode;
    assign o_selection_reset = r_result.selection_reset;
    assign o_edit_touched    = r_result.edit_touched;
    assign o_display_refresh = r_result.display_refresh;

endmodule
